/* hw/rtl/edidb_pkg.sv */
// Shared types, constants and the fixed-byte table of the EDID base block reader.
// No dependencies; imported by edidb_dtd_pack and edid_block_from_timings_top.
package edidb_pkg;

  // Configuration register indexes, in the order of the register list.
  typedef enum logic [2:0] {
    REG_ACTIVE_WIDTH  = 3'd0,
    REG_ACTIVE_HEIGHT = 3'd1,
    REG_H_PORCHES     = 3'd2,
    REG_V_PORCHES     = 3'd3,
    REG_FRAME_RATE    = 3'd4,
    REG_VENDOR_CODE   = 3'd5,
    REG_PHYS_SIZE     = 3'd6,
    REG_BORDER_SIZES  = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [7:0] FRAME_RATE_RESET = 8'd60;

  // Byte offsets with special treatment.
  localparam logic [6:0] OFS_VENDOR_LO = 7'd8;
  localparam logic [6:0] OFS_VENDOR_HI = 7'd9;
  localparam logic [6:0] OFS_DTD       = 7'd54;
  localparam logic [6:0] OFS_PCLK_LO   = 7'd54;
  localparam logic [6:0] OFS_PCLK_HI   = 7'd55;
  localparam logic [6:0] OFS_DTD_VAR_LO = 7'd56;
  localparam logic [6:0] OFS_DTD_VAR_HI = 7'd70;
  localparam logic [6:0] OFS_CHECKSUM  = 7'd127;

  // Variable bytes: vendor low and high in entries 0 and 1, descriptor byte i
  // (offset 54 + i) in entry i for i from 2 to 16.
  localparam int unsigned NUM_VB = 17;
  localparam int unsigned VB_IDX_W = 5;
  typedef logic [NUM_VB-1:0][7:0] vb_bytes_t;

  // Horizontal and vertical totals of the timing.
  typedef struct packed {
    logic [13:0] h_total;
    logic [13:0] v_total;
  } totals_t;

  // Division by 10000: shift right by 4, then multiply by the reciprocal of
  // 625 rounded up to 2^38 / 625; exact for every 28-bit dividend.
  localparam int unsigned DIV_PRE_SHIFT = 4;
  localparam int unsigned RECIP_SHIFT   = 38;
  localparam logic [28:0] RECIP_625     = 29'd439804652;

  // Bytes of the block that never change; variable positions read as zero.
  function automatic logic [7:0] edidb_fixed_byte(input logic [6:0] ofs);
    logic [7:0] b;
    b = 8'h00;
    priority if (ofs == 7'd0 || ofs == 7'd7) begin
      b = 8'h00;
    end else if (ofs <= 7'd6) begin
      b = 8'hff;
    end else if (ofs >= 7'd10 && ofs <= 7'd17) begin
      b = 8'hff;
    end else if (ofs == 7'd18) begin
      b = 8'h01;
    end else if (ofs == 7'd19) begin
      b = 8'h03;
    end else if (ofs == 7'd20) begin
      b = 8'h80;
    end else if (ofs >= 7'd21 && ofs <= 7'd23) begin
      b = 8'hff;
    end else if (ofs == 7'd24) begin
      b = 8'hee;
    end else if (ofs >= 7'd25 && ofs <= 7'd34) begin
      b = 8'hff;
    end else if (ofs == 7'd71) begin
      b = 8'h1a;
    end else begin
      b = 8'h00;
    end
    return b;
  endfunction

  // Sum of the fixed bytes 0 to 126, worked out at elaboration.
  function automatic logic [7:0] edidb_fixed_sum();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < 127; i++) begin
      s = s + edidb_fixed_byte(7'(i));
    end
    return s;
  endfunction

  localparam logic [7:0] FIXED_SUM = edidb_fixed_sum();

endpackage

/* hw/rtl/edidb_dtd_pack.sv */
// Packs the timing registers into the variable bytes of the EDID block and
// forms the horizontal and vertical totals. Depends on edidb_pkg.
module edidb_dtd_pack (
  input  logic [11:0]         active_width,
  input  logic [11:0]         active_height,
  input  logic [35:0]         horizontal_porches,
  input  logic [35:0]         vertical_porches,
  input  logic [15:0]         vendor_code,
  input  logic [23:0]         physical_size,
  input  logic [63:0]         border_sizes,
  output edidb_pkg::totals_t  totals,
  output edidb_pkg::vb_bytes_t vb
);
  import edidb_pkg::*;

  logic [11:0] hfp, hbp, hsw, vfp, vbp, vsw, pw, pl;
  logic [13:0] hbl, vbl;
  logic [16:0] lr_sum, tb_sum;

  // Porch fields and physical size fields.
  assign hfp = horizontal_porches[11:0];
  assign hbp = horizontal_porches[23:12];
  assign hsw = horizontal_porches[35:24];
  assign vfp = vertical_porches[11:0];
  assign vbp = vertical_porches[23:12];
  assign vsw = vertical_porches[35:24];
  assign pw  = physical_size[11:0];
  assign pl  = physical_size[23:12];

  // Blanking sums never wrap in 14 bits.
  assign hbl = 14'(hfp) + 14'(hbp) + 14'(hsw);
  assign vbl = 14'(vfp) + 14'(vbp) + 14'(vsw);

  assign totals.h_total = 14'(active_width) + hbl;
  assign totals.v_total = 14'(active_height) + vbl;

  // Border pairs are summed in 17 bits and halved.
  assign lr_sum = 17'(border_sizes[15:0]) + 17'(border_sizes[31:16]);
  assign tb_sum = 17'(border_sizes[47:32]) + 17'(border_sizes[63:48]);

  // Byte layout of the vendor id and the first detailed timing descriptor.
  always_comb begin
    vb     = '0;
    vb[0]  = vendor_code[7:0];
    vb[1]  = vendor_code[15:8];
    vb[2]  = active_width[7:0];
    vb[3]  = hbl[7:0];
    vb[4]  = {active_width[11:8], hbl[11:8]};
    vb[5]  = active_height[7:0];
    vb[6]  = vbl[7:0];
    vb[7]  = {active_height[11:8], vbl[11:8]};
    vb[8]  = hfp[7:0];
    vb[9]  = hsw[7:0];
    vb[10] = {vfp[3:0], vsw[3:0]};
    vb[11] = {hfp[9:8], hsw[9:8], vfp[5:4], vsw[5:4]};
    vb[12] = pw[7:0];
    vb[13] = pl[7:0];
    vb[14] = {pw[11:8], pl[11:8]};
    vb[15] = lr_sum[8:1];
    vb[16] = tb_sum[8:1];
  end

endmodule

/* hw/rtl/edid_block_from_timings_top.sv */
// Top level of the EDID 1.3 base block reader: configuration registers and a
// five-stage read pipeline. Depends on edidb_pkg and edidb_dtd_pack.
//
//   Channel | Direction | Handshake         | Payload
//   in_     | input     | in_valid/in_stall  | in_byte_offset (7 bits)
//   out_    | output    | out_valid/out_stall| out_byte_value (8 bits)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index (8), cfg_data (64)
//
// One item is accepted per cycle while in_stall is low; its byte passes through the
// pipeline, whose depth is set by the two multiplies of the pixel clock path and
// the reciprocal divide by 10000 that each item carries through the stages.
// Reset clears the stage valid bits and sets the configuration registers to their defaults.
// A stall on the output holds the result; earlier stages keep filling until
// the pipeline is full, and only then is the input stalled.
module edid_block_from_timings_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [6:0]                        in_byte_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [edidb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [edidb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import edidb_pkg::*;

  // Configuration registers.
  logic [11:0] active_width_r, active_height_r;
  logic [35:0] h_porches_r, v_porches_r;
  logic [7:0]  frame_rate_r;
  logic [15:0] vendor_code_r;
  logic [23:0] phys_size_r;
  logic [63:0] border_sizes_r;

  // Pipeline stage registers.
  logic              v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [6:0]        off1_r, off2_r, off3_r, off4_r;
  totals_t           tot1_r;
  logic [7:0]        fr1_r, fr2_r;
  vb_bytes_t         vb1_r;
  logic [27:0]       prod2_r;
  logic [3:0][7:0]   psum2_r;
  logic [7:0]        sel2_r, sel3_r, sel4_r;
  logic [31:0]       x3_r;
  logic [7:0]        vsum3_r, vsum4_r;
  logic [15:0]       q4_r;
  logic [7:0]        out_byte_value_r;

  logic              rdy1, rdy2, rdy3, rdy4, rdy5;
  logic              in_acc;
  totals_t           tot_nxt;
  vb_bytes_t         vb_nxt;
  logic [27:0]       prod2_nxt;
  logic [3:0][7:0]   psum2_nxt;
  logic [7:0]        sel2_nxt, vsum3_nxt, cks, out_byte_value_nxt;
  logic [35:0]       scaled;
  logic [27:0]       div_in;
  logic [56:0]       recip_prod;
  logic [15:0]       q4_nxt;
  logic [6:0]        vb_ofs;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= '0;
      active_height_r <= '0;
      h_porches_r     <= '0;
      v_porches_r     <= '0;
      frame_rate_r    <= FRAME_RATE_RESET;
      vendor_code_r   <= '0;
      phys_size_r     <= '0;
      border_sizes_r  <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index[CFG_INDEX_W-1:3] == '0) begin
      unique case (cfg_reg_t'(cfg_index[2:0]))
        REG_ACTIVE_WIDTH:  active_width_r  <= cfg_data[11:0];
        REG_ACTIVE_HEIGHT: active_height_r <= cfg_data[11:0];
        REG_H_PORCHES:     h_porches_r     <= cfg_data[35:0];
        REG_V_PORCHES:     v_porches_r     <= cfg_data[35:0];
        REG_FRAME_RATE:    frame_rate_r    <= cfg_data[7:0];
        REG_VENDOR_CODE:   vendor_code_r   <= cfg_data[15:0];
        REG_PHYS_SIZE:     phys_size_r     <= cfg_data[23:0];
        REG_BORDER_SIZES:  border_sizes_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage loads when it is empty or the stage after it moves on.
  assign rdy5     = !v5_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_acc;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: byte packing and timing totals from the registers.
  edidb_dtd_pack u_pack (
    .active_width       (active_width_r),
    .active_height      (active_height_r),
    .horizontal_porches (h_porches_r),
    .vertical_porches   (v_porches_r),
    .vendor_code        (vendor_code_r),
    .physical_size      (phys_size_r),
    .border_sizes       (border_sizes_r),
    .totals             (tot_nxt),
    .vb                 (vb_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy1) begin
      off1_r <= in_byte_offset;
      tot1_r <= tot_nxt;
      fr1_r  <= frame_rate_r;
      vb1_r  <= vb_nxt;
    end
  end

  // Stage 2: total pixel count, partial checksum sums and the byte select.
  assign prod2_nxt    = tot1_r.v_total * tot1_r.h_total;
  assign psum2_nxt[0] = vb1_r[0] + vb1_r[1] + vb1_r[2] + vb1_r[3] + vb1_r[4];
  assign psum2_nxt[1] = vb1_r[5] + vb1_r[6] + vb1_r[7] + vb1_r[8];
  assign psum2_nxt[2] = vb1_r[9] + vb1_r[10] + vb1_r[11] + vb1_r[12];
  assign psum2_nxt[3] = vb1_r[13] + vb1_r[14] + vb1_r[15] + vb1_r[16];
  assign vb_ofs       = off1_r - OFS_DTD;

  always_comb begin
    priority if (off1_r == OFS_VENDOR_LO) begin
      sel2_nxt = vb1_r[0];
    end else if (off1_r == OFS_VENDOR_HI) begin
      sel2_nxt = vb1_r[1];
    end else if (off1_r >= OFS_DTD_VAR_LO && off1_r <= OFS_DTD_VAR_HI) begin
      sel2_nxt = vb1_r[vb_ofs[VB_IDX_W-1:0]];
    end else begin
      sel2_nxt = edidb_fixed_byte(off1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      off2_r  <= off1_r;
      prod2_r <= prod2_nxt;
      fr2_r   <= fr1_r;
      psum2_r <= psum2_nxt;
      sel2_r  <= sel2_nxt;
    end
  end

  // Stage 3: scale by the frame rate, wrapping at 32 bits.
  assign scaled    = prod2_r * fr2_r;
  assign vsum3_nxt = psum2_r[0] + psum2_r[1] + psum2_r[2] + psum2_r[3];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      off3_r  <= off2_r;
      x3_r    <= scaled[31:0];
      vsum3_r <= vsum3_nxt;
      sel3_r  <= sel2_r;
    end
  end

  // Stage 4: divide by 10000 through the reciprocal of 625.
  assign div_in     = x3_r[31:DIV_PRE_SHIFT];
  assign recip_prod = div_in * RECIP_625;
  assign q4_nxt     = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      off4_r  <= off3_r;
      q4_r    <= q4_nxt;
      vsum4_r <= vsum3_r;
      sel4_r  <= sel3_r;
    end
  end

  // Stage 5: pixel clock bytes, checksum and the output register.
  assign cks = 8'h00 - (FIXED_SUM + vsum4_r + q4_r[7:0] + q4_r[15:8]);

  always_comb begin
    priority if (off4_r == OFS_PCLK_LO) begin
      out_byte_value_nxt = q4_r[7:0];
    end else if (off4_r == OFS_PCLK_HI) begin
      out_byte_value_nxt = q4_r[15:8];
    end else if (off4_r == OFS_CHECKSUM) begin
      out_byte_value_nxt = cks;
    end else begin
      out_byte_value_nxt = sel4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_byte_value_r <= out_byte_value_nxt;
    end
  end

  assign out_valid      = v5_r;
  assign out_byte_value = out_byte_value_r;

  // An accepted item occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> v1_r)
    else $error("accepted item did not enter the first stage");

  // With every stage full and the output stalled, the input must be stalled.
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && out_stall) |-> in_stall)
    else $error("input accepted while the pipeline is full and stalled");

  // A stage 4 item blocked by a stalled output keeps its offset and quotient.
  a_stage4_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !rdy5) |=> (v4_r && $stable(off4_r) && $stable(q4_r)))
    else $error("stage 4 item changed while blocked");

endmodule
